@@ hw/rtl/mwe_pkg.sv @@
package mwe_pkg;

    localparam int MAX_POSITIONS_DEF = 8;
    localparam int CHARSET_DEPTH_DEF = 256;

    localparam int OP_W    = 2;
    localparam int POS_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 9;

    // Number of distinct character codes, one seen-map entry each.
    localparam int CHAR_SPAN = 1 << CHAR_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD     = 2'd1,
        OP_RESTART = 2'd2,
        OP_NEXT    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD_IDX,
        S_ADD_CHK,
        S_ADD_WR,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [POS_W-1:0]   changed_position;
        logic               exhausted;
        logic [COUNT_W-1:0] char_count;
    } t_rsp;

    typedef struct packed {
        logic seen_rd;
        logic store_rd;
        logic wr;
    } t_ram_ctl;

endpackage

@@ hw/rtl/mwe_req_if.sv @@
interface mwe_req_if;
    logic                       valid;
    logic                       ready;
    logic [mwe_pkg::OP_W-1:0]   operation;
    logic [mwe_pkg::POS_W-1:0]  position;
    logic [mwe_pkg::CHAR_W-1:0] char_value;
    logic [mwe_pkg::LEN_W-1:0]  word_length;

    modport source (output valid, operation, position, char_value, word_length, input ready);
    modport sink   (input valid, operation, position, char_value, word_length, output ready);
endinterface

@@ hw/rtl/mwe_rsp_if.sv @@
interface mwe_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mwe_pkg::WORD_W-1:0]  word;
    logic [mwe_pkg::POS_W-1:0]   changed_position;
    logic                        exhausted;
    logic [mwe_pkg::COUNT_W-1:0] char_count;

    modport source (output valid, word, changed_position, exhausted, char_count, input ready);
    modport sink   (input valid, word, changed_position, exhausted, char_count, output ready);
endinterface

@@ hw/rtl/mask_word_enumerator_core.sv @@
// Channel  Dir  Interface   Payload
// i_req    in   mwe_req_if  operation, position, char_value, word_length
// o_rsp    out  mwe_rsp_if  word, changed_position, exhausted, char_count
//
// One request is worked on at a time; a next request walks the positions
// from the last one down, with one charset memory read per position walked.
// Synchronous reset clears charset sizes, cursors, word and length; the
// charset memories need no clearing pass since seen entries are verified.
// A result waits in the output register while a new request may be taken;
// a finished request holds in its last state until that register is free.
module mask_word_enumerator_core #(
    parameter int MAX_POSITIONS = mwe_pkg::MAX_POSITIONS_DEF,
    parameter int CHARSET_DEPTH = mwe_pkg::CHARSET_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwe_req_if.sink   i_req,
    mwe_rsp_if.source o_rsp
);
    import mwe_pkg::*;

    localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int CW = $clog2(CHARSET_DEPTH);

    t_ram_ctl          ram_ctl;
    logic [PW-1:0]     ram_pos;
    logic [CHAR_W-1:0] ram_char;
    logic [CW-1:0]     ram_rd_idx, ram_wr_idx, seen_idx;
    logic [CHAR_W-1:0] store_char;
    logic              push, load_ok;
    t_rsp              rsp;

    logic              r_out_valid, n_out_valid;
    t_rsp              r_out;

    mwe_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .CHARSET_DEPTH (CHARSET_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_operation   (i_req.operation),
        .i_position    (i_req.position),
        .i_char_value  (i_req.char_value),
        .i_word_length (i_req.word_length),
        .i_load_ok     (load_ok),
        .o_push        (push),
        .o_rsp         (rsp),
        .o_ram_ctl     (ram_ctl),
        .o_ram_pos     (ram_pos),
        .o_ram_char    (ram_char),
        .o_ram_rd_idx  (ram_rd_idx),
        .o_ram_wr_idx  (ram_wr_idx),
        .i_seen_idx    (seen_idx),
        .i_store_char  (store_char)
    );

    mwe_charset_ram #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .CHARSET_DEPTH (CHARSET_DEPTH)
    ) u_ram (
        .i_clk        (i_clk),
        .i_ctl        (ram_ctl),
        .i_pos        (ram_pos),
        .i_char       (ram_char),
        .i_rd_idx     (ram_rd_idx),
        .i_wr_idx     (ram_wr_idx),
        .o_seen_idx   (seen_idx),
        .o_store_char (store_char)
    );

    assign load_ok = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (push) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.word             = r_out.word;
    assign o_rsp.changed_position = r_out.changed_position;
    assign o_rsp.exhausted        = r_out.exhausted;
    assign o_rsp.char_count       = r_out.char_count;
endmodule

@@ hw/rtl/mwe_step_unit.sv @@
module mwe_step_unit #(
    parameter int SW = 9
) (
    input  logic [SW-1:0] i_a,
    input  logic [SW-1:0] i_b,
    output logic          o_lt,
    output logic [SW-1:0] o_inc
);
    assign o_lt  = (i_a < i_b);
    assign o_inc = i_a + SW'(1);
endmodule

@@ hw/rtl/mwe_charset_ram.sv @@
module mwe_charset_ram #(
    parameter int MAX_POSITIONS = mwe_pkg::MAX_POSITIONS_DEF,
    parameter int CHARSET_DEPTH = mwe_pkg::CHARSET_DEPTH_DEF,
    localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
    localparam int CW = $clog2(CHARSET_DEPTH)
) (
    input  logic                       i_clk,
    input  mwe_pkg::t_ram_ctl          i_ctl,
    input  logic [PW-1:0]              i_pos,
    input  logic [mwe_pkg::CHAR_W-1:0] i_char,
    input  logic [CW-1:0]              i_rd_idx,
    input  logic [CW-1:0]              i_wr_idx,
    output logic [CW-1:0]              o_seen_idx,
    output logic [mwe_pkg::CHAR_W-1:0] o_store_char
);
    import mwe_pkg::*;

    // The seen map holds, per character, the charset slot where it was stored.
    // An entry only counts when that slot is below the size and still holds the
    // character, so neither memory needs clearing.
    logic [CW-1:0]     r_seen  [MAX_POSITIONS][CHAR_SPAN];
    logic [CHAR_W-1:0] r_store [MAX_POSITIONS][CHARSET_DEPTH];
    logic [CW-1:0]     r_seen_q;
    logic [CHAR_W-1:0] r_store_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_seen[i_pos][i_char]    <= i_wr_idx;
            r_store[i_pos][i_wr_idx] <= i_char;
        end
        if (i_ctl.seen_rd) begin
            r_seen_q <= r_seen[i_pos][i_char];
        end
        if (i_ctl.store_rd) begin
            r_store_q <= r_store[i_pos][i_rd_idx];
        end
    end

    assign o_seen_idx   = r_seen_q;
    assign o_store_char = r_store_q;
endmodule

@@ hw/rtl/mwe_ctrl.sv @@
module mwe_ctrl #(
    parameter int MAX_POSITIONS = mwe_pkg::MAX_POSITIONS_DEF,
    parameter int CHARSET_DEPTH = mwe_pkg::CHARSET_DEPTH_DEF,
    localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
    localparam int CW = $clog2(CHARSET_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [mwe_pkg::OP_W-1:0]    i_operation,
    input  logic [mwe_pkg::POS_W-1:0]   i_position,
    input  logic [mwe_pkg::CHAR_W-1:0]  i_char_value,
    input  logic [mwe_pkg::LEN_W-1:0]   i_word_length,
    input  logic                        i_load_ok,
    output logic                        o_push,
    output mwe_pkg::t_rsp               o_rsp,
    output mwe_pkg::t_ram_ctl           o_ram_ctl,
    output logic [PW-1:0]               o_ram_pos,
    output logic [mwe_pkg::CHAR_W-1:0]  o_ram_char,
    output logic [CW-1:0]               o_ram_rd_idx,
    output logic [CW-1:0]               o_ram_wr_idx,
    input  logic [CW-1:0]               i_seen_idx,
    input  logic [mwe_pkg::CHAR_W-1:0]  i_store_char
);
    import mwe_pkg::*;

    localparam int SW = $clog2(CHARSET_DEPTH + 1);
    localparam int KW = $clog2(MAX_POSITIONS + 1);

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [LEN_W-1:0]  r_len, n_len;

    logic [SW-1:0]     r_size   [MAX_POSITIONS];
    logic [SW-1:0]     n_size   [MAX_POSITIONS];
    logic [SW-1:0]     r_cursor [MAX_POSITIONS];
    logic [SW-1:0]     n_cursor [MAX_POSITIONS];
    logic [CHAR_W-1:0] r_word   [MAX_POSITIONS];
    logic [CHAR_W-1:0] n_word   [MAX_POSITIONS];
    logic [KW-1:0]     r_active, n_active;

    logic [KW-1:0]     r_k, n_k;
    logic              r_pend, n_pend;
    logic [PW-1:0]     r_pend_i, n_pend_i;
    logic              r_pend_zero, n_pend_zero;
    logic              r_stop, n_stop;
    logic              r_hit, n_hit;
    logic [PW-1:0]     r_changed, n_changed;
    logic              r_exh, n_exh;
    logic [SW-1:0]     r_count, n_count;

    logic [SW-1:0]     unit_a, unit_b, unit_inc;
    logic              unit_lt;
    logic [PW-1:0]     pidx, walk_i;
    logic              pos_ok;
    logic [KW-1:0]     len_sat;
    logic [WORD_W-1:0] packed_word;

    mwe_step_unit #(.SW(SW)) u_step (
        .i_a   (unit_a),
        .i_b   (unit_b),
        .o_lt  (unit_lt),
        .o_inc (unit_inc)
    );

    assign pidx    = r_pos[PW-1:0];
    assign walk_i  = PW'(r_k - KW'(1));
    assign pos_ok  = ({1'b0, r_pos} < 4'(MAX_POSITIONS));
    assign len_sat = (int'(r_len) > MAX_POSITIONS) ? KW'(MAX_POSITIONS) : KW'(r_len);

    assign o_ram_pos    = (r_state == S_WALK) ? walk_i : pidx;
    assign o_ram_char   = r_char;
    assign o_ram_wr_idx = r_size[pidx][CW-1:0];

    always_comb begin
        packed_word = '0;
        for (int i = 0; i < MAX_POSITIONS; i++) begin
            if (i < int'(r_active)) begin
                packed_word[8*i +: 8] = r_word[i];
            end
        end
    end

    assign o_rsp.word             = packed_word;
    assign o_rsp.changed_position = POS_W'(r_changed);
    assign o_rsp.exhausted        = r_exh;
    assign o_rsp.char_count       = COUNT_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_char      = r_char;
        n_len       = r_len;
        n_size      = r_size;
        n_cursor    = r_cursor;
        n_word      = r_word;
        n_active    = r_active;
        n_k         = r_k;
        n_pend      = r_pend;
        n_pend_i    = r_pend_i;
        n_pend_zero = r_pend_zero;
        n_stop      = r_stop;
        n_hit       = r_hit;
        n_changed   = r_changed;
        n_exh       = r_exh;
        n_count     = r_count;
        o_ram_ctl   = '0;
        o_ram_rd_idx = '0;
        unit_a      = '0;
        unit_b      = '0;
        o_req_ready = 1'b0;
        o_push      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op    = t_op'(i_operation);
                    n_pos   = i_position;
                    n_char  = i_char_value;
                    n_len   = i_word_length;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_changed = '0;
                n_exh     = 1'b0;
                n_count   = '0;
                n_pend    = 1'b0;
                n_stop    = 1'b0;
                unique case (r_op)
                    OP_CLEAR: begin
                        if (pos_ok) begin
                            n_size[pidx]   = '0;
                            n_cursor[pidx] = '0;
                        end
                        n_state = S_DONE;
                    end
                    OP_ADD: begin
                        if (pos_ok) begin
                            o_ram_ctl.seen_rd = 1'b1;
                            n_state = S_ADD_IDX;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_RESTART: begin
                        n_active = len_sat;
                        for (int i = 0; i < MAX_POSITIONS; i++) begin
                            if (i < int'(len_sat)) begin
                                n_cursor[i] = r_size[i];
                            end
                        end
                        n_cursor[0] = '0;
                        n_state = S_DONE;
                    end
                    OP_NEXT: begin
                        n_k     = r_active;
                        n_state = S_WALK;
                    end
                endcase
            end
            S_ADD_IDX: begin
                o_ram_ctl.store_rd = 1'b1;
                o_ram_rd_idx = i_seen_idx;
                n_state = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                // A seen-map hit is only real if its slot is live and holds this byte.
                unit_a = SW'(i_seen_idx);
                unit_b = r_size[pidx];
                n_hit  = 1'b0;
                if (unit_lt && (i_store_char == r_char)) begin
                    n_hit = 1'b1;
                end
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                unit_a  = r_size[pidx];
                unit_b  = SW'(CHARSET_DEPTH);
                n_count = r_size[pidx];
                if (!r_hit && unit_lt) begin
                    o_ram_ctl.wr = 1'b1;
                    n_size[pidx] = unit_inc;
                    n_count      = unit_inc;
                end
                n_state = S_DONE;
            end
            S_WALK: begin
                // Write back the character read for the previous position.
                if (r_pend) begin
                    n_word[r_pend_i] = r_pend_zero ? '0 : i_store_char;
                end
                if (r_stop) begin
                    n_state = S_DONE;
                end else if (r_k == '0) begin
                    n_exh     = 1'b1;
                    n_changed = '0;
                    n_state   = S_DONE;
                end else begin
                    unit_a = r_cursor[walk_i];
                    unit_b = r_size[walk_i];
                    o_ram_ctl.store_rd = 1'b1;
                    o_ram_rd_idx = unit_lt ? r_cursor[walk_i][CW-1:0] : '0;
                    n_cursor[walk_i] = unit_lt ? unit_inc : SW'(1);
                    n_pend      = 1'b1;
                    n_pend_i    = walk_i;
                    n_pend_zero = (r_size[walk_i] == '0);
                    if (unit_lt) begin
                        n_changed = walk_i;
                        n_stop    = 1'b1;
                    end else begin
                        n_k = r_k - KW'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_load_ok) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= '{default: '0};
            r_cursor <= '{default: '0};
            r_word   <= '{default: '0};
            r_active <= '0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_cursor <= n_cursor;
            r_word   <= n_word;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_char      <= n_char;
        r_len       <= n_len;
        r_k         <= n_k;
        r_pend      <= n_pend;
        r_pend_i    <= n_pend_i;
        r_pend_zero <= n_pend_zero;
        r_stop      <= n_stop;
        r_hit       <= n_hit;
        r_changed   <= n_changed;
        r_exh       <= n_exh;
        r_count     <= n_count;
    end
endmodule

@@ hw/rtl/mwe_checker.sv @@
module mwe_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [mwe_pkg::WORD_W-1:0]  i_word,
    input logic [mwe_pkg::POS_W-1:0]   i_changed_position,
    input logic                        i_exhausted,
    input logic [mwe_pkg::COUNT_W-1:0] i_char_count
);
    import mwe_pkg::*;

    // The sequencer takes one request and is busy on the following cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while the previous one is in progress");

    a_exhausted_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_exhausted |-> i_changed_position == '0)
        else $error("exhausted result carries a nonzero changed position");

    // Only an add reports a charset size; next results never do.
    a_count_only_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_exhausted || i_changed_position != '0) |-> i_char_count == '0)
        else $error("next result carries a nonzero char count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_word))
        else $error("stalled result dropped or changed");
endmodule

bind mask_word_enumerator_core mwe_checker u_mwe_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_word             (o_rsp.word),
    .i_changed_position (o_rsp.changed_position),
    .i_exhausted        (o_rsp.exhausted),
    .i_char_count       (o_rsp.char_count)
);

@@ sim/mask_word_enumerator_core_tb.sv @@
module mask_word_enumerator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwe_pkg::*;

    localparam int NUM_POS = MAX_POSITIONS_DEF;
    localparam int RANDOM_REQS = 800;

    typedef struct {
        t_op              operation;
        logic [POS_W-1:0] position;
        logic [CHAR_W-1:0] char_value;
        logic [LEN_W-1:0] word_length;
        bit               drain;
    } t_mask_req;

    logic i_clk;
    logic i_rst_n;

    mwe_req_if req_if ();
    mwe_rsp_if rsp_if ();

    mask_word_enumerator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the charsets, odometer and current word.
    logic [CHAR_W-1:0] charset_chars [NUM_POS][CHAR_SPAN];
    bit                charset_seen  [NUM_POS][CHAR_SPAN];
    int                charset_len   [NUM_POS];
    int                walk_ptr      [NUM_POS];
    logic [CHAR_W-1:0] word_bytes    [NUM_POS];
    int                word_span;

    t_mask_req mask_ops_q[$];
    t_rsp      expected_words[$];
    int        reqs_queued;
    int        mismatches;

    bit req_taken;
    bit rsp_taken;
    bit req_active;
    int req_gap;
    bit req_burst;
    int rsp_stall;
    bit rsp_burst;

    always #5 i_clk = ~i_clk;

    function automatic t_rsp enumerate_step(t_mask_req r);
        t_rsp res;
        int   p;
        int   k;
        int   len;
        bit   moved;
        res = '0;
        p = r.position;
        case (r.operation)
            OP_CLEAR: begin
                charset_len[p] = 0;
                walk_ptr[p] = 0;
                for (k = 0; k < CHAR_SPAN; k++) charset_seen[p][k] = 1'b0;
            end
            OP_ADD: begin
                if (!charset_seen[p][r.char_value] && charset_len[p] < CHARSET_DEPTH_DEF) begin
                    charset_seen[p][r.char_value] = 1'b1;
                    charset_chars[p][charset_len[p]] = r.char_value;
                    charset_len[p]++;
                end
                res.char_count = COUNT_W'(charset_len[p]);
            end
            OP_RESTART: begin
                len = (r.word_length > NUM_POS) ? NUM_POS : int'(r.word_length);
                word_span = len;
                for (k = 0; k < len; k++) walk_ptr[k] = charset_len[k];
                walk_ptr[0] = 0;
            end
            default: begin
                // Odometer: the last position turns first, wrapped positions restart at
                // their first character (or 0 when the charset is empty).
                k = word_span;
                moved = 1'b0;
                while (k > 0 && !moved) begin
                    p = k - 1;
                    if (walk_ptr[p] < charset_len[p]) begin
                        word_bytes[p] = charset_chars[p][walk_ptr[p]];
                        walk_ptr[p]++;
                        res.changed_position = POS_W'(p);
                        moved = 1'b1;
                    end else begin
                        word_bytes[p] = (charset_len[p] == 0) ? '0 : charset_chars[p][0];
                        walk_ptr[p] = 1;
                        k--;
                    end
                end
                if (!moved) begin
                    res.exhausted = 1'b1;
                    res.changed_position = '0;
                end
            end
        endcase
        for (k = 0; k < word_span; k++) res.word[8*k +: 8] = word_bytes[k];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_req(t_op op, int pos, int ch, int len, bit drain = 1'b0);
        t_mask_req it;
        it.operation = op;
        it.position = POS_W'(pos);
        it.char_value = CHAR_W'(ch);
        it.word_length = LEN_W'(len);
        it.drain = drain;
        mask_ops_q.push_back(it);
        reqs_queued++;
    endtask

    // Requests: one is dropped onto the bus after a random gap and held until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_active = 1'b0;
            req_gap = 0;
        end else begin
            if (req_active && req_taken) req_active = 1'b0;
            if (!req_active) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (mask_ops_q.size() > 0 &&
                             !(mask_ops_q[0].drain && expected_words.size() > 0)) begin
                    req_if.operation   <= mask_ops_q[0].operation;
                    req_if.position    <= mask_ops_q[0].position;
                    req_if.char_value  <= mask_ops_q[0].char_value;
                    req_if.word_length <= mask_ops_q[0].word_length;
                    void'(mask_ops_q.pop_front());
                    req_active = 1'b1;
                    if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
                    req_gap = req_burst ? 0 : $urandom_range(0, 8);
                end
            end
            req_if.valid <= req_active;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end else begin
            if (rsp_taken) begin
                if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
                rsp_stall = rsp_burst ? 0 : $urandom_range(0, 8);
            end else if (rsp_stall > 0) begin
                rsp_stall--;
            end
            rsp_if.ready <= (rsp_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        t_mask_req r;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        rsp_taken <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", rsp_if.word, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (rsp_if.word !== want.word)
                        report_mismatch("word", rsp_if.word, want.word);
                    if (rsp_if.changed_position !== want.changed_position)
                        report_mismatch("changed_position", rsp_if.changed_position,
                                        want.changed_position);
                    if (rsp_if.exhausted !== want.exhausted)
                        report_mismatch("exhausted", rsp_if.exhausted, want.exhausted);
                    if (rsp_if.char_count !== want.char_count)
                        report_mismatch("char_count", rsp_if.char_count, want.char_count);
                end
            end
            if (req_if.valid && req_if.ready) begin
                r.operation = t_op'(req_if.operation);
                r.position = req_if.position;
                r.char_value = req_if.char_value;
                r.word_length = req_if.word_length;
                r.drain = 1'b0;
                expected_words.push_back(enumerate_step(r));
            end
        end
    end

    initial begin
        int p;
        int k;
        int n;
        int len;
        int base;
        int tmp;
        int perm[CHAR_SPAN];
        bit filled_full;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_CLEAR;
        req_if.position = '0;
        req_if.char_value = '0;
        req_if.word_length = '0;
        rsp_if.ready = 1'b0;
        mismatches = 0;
        reqs_queued = 0;
        req_burst = 1'b0;
        rsp_burst = 1'b0;
        filled_full = 1'b0;
        word_span = 0;
        for (p = 0; p < NUM_POS; p++) begin
            charset_len[p] = 0;
            walk_ptr[p] = 0;
            word_bytes[p] = '0;
            for (k = 0; k < CHAR_SPAN; k++) begin
                charset_chars[p][k] = '0;
                charset_seen[p][k] = 1'b0;
            end
        end

        // Directed: empty length, duplicates, clear keeping old characters,
        // saturated length, empty charsets inside the word, stepping past exhaustion.
        queue_req(OP_NEXT, 7, 8'hFF, 15);
        queue_req(OP_RESTART, 7, 8'hFF, 0);
        queue_req(OP_NEXT, 0, 0, 0);
        queue_req(OP_ADD, 0, 8'h00, 0);
        queue_req(OP_ADD, 0, 8'hFF, 15);
        queue_req(OP_ADD, 0, 8'hFF, 8);
        queue_req(OP_ADD, 7, 8'hA5, 5);
        queue_req(OP_ADD, 7, 8'h5A, 10);
        queue_req(OP_CLEAR, 0, 8'h33, 3);
        queue_req(OP_ADD, 0, 8'h41, 1);
        queue_req(OP_ADD, 0, 8'h00, 2);
        queue_req(OP_RESTART, 2, 8'h80, 15, 1'b1);
        for (k = 0; k < 5; k++) queue_req(OP_NEXT, k, 8'h7F, 9);
        queue_req(OP_RESTART, 5, 8'h01, 9);
        queue_req(OP_RESTART, 3, 8'hC3, 1);
        for (k = 0; k < 3; k++) queue_req(OP_NEXT, 6, 8'h3C, 4);
        queue_req(OP_CLEAR, 7, 8'hFE, 12);
        queue_req(OP_RESTART, 1, 8'h10, 8);
        queue_req(OP_NEXT, 4, 8'h08, 6);

        n = reqs_queued;
        while (reqs_queued < n + RANDOM_REQS) begin
            k = $urandom_range(0, 9);
            if (!filled_full && reqs_queued > n + 300) begin
                // Fill one position with every byte value in shuffled order.
                filled_full = 1'b1;
                p = $urandom_range(0, NUM_POS - 1);
                for (k = 0; k < CHAR_SPAN; k++) perm[k] = k;
                for (k = CHAR_SPAN - 1; k > 0; k--) begin
                    base = $urandom_range(0, k);
                    tmp = perm[k];
                    perm[k] = perm[base];
                    perm[base] = tmp;
                end
                queue_req(OP_CLEAR, p, $urandom_range(0, 255), $urandom_range(0, 15));
                for (k = 0; k < CHAR_SPAN; k++)
                    queue_req(OP_ADD, p, perm[k], $urandom_range(0, 15));
                for (k = 0; k < 3; k++)
                    queue_req(OP_ADD, p, $urandom_range(0, 255), $urandom_range(0, 15));
                queue_req(OP_RESTART, $urandom_range(0, 7), $urandom_range(0, 255), p + 1);
                for (k = 0; k < 6; k++)
                    queue_req(OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 255),
                              $urandom_range(0, 15));
            end else if (k <= 6) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
                for (p = 0; p < len; p++) begin
                    if ($urandom_range(0, 2) != 0) continue;
                    queue_req(OP_CLEAR, p, $urandom_range(0, 255), $urandom_range(0, 15));
                    tmp = (len > 3) ? $urandom_range(0, 2) : $urandom_range(0, 4);
                    base = $urandom_range(0, 255);
                    for (k = 0; k < tmp; k++)
                        queue_req(OP_ADD, p, (base + $urandom_range(0, 5)) & 8'hFF,
                                  $urandom_range(0, 15));
                end
                if (len == NUM_POS && $urandom_range(0, 1) == 0) len = $urandom_range(8, 15);
                queue_req(OP_RESTART, $urandom_range(0, 7), $urandom_range(0, 255), len,
                          $urandom_range(0, 7) == 0);
                tmp = $urandom_range(1, 20);
                for (k = 0; k < tmp; k++)
                    queue_req(OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 255),
                              $urandom_range(0, 15));
            end else if (k <= 8) begin
                tmp = $urandom_range(1, 6);
                for (k = 0; k < tmp; k++)
                    queue_req(t_op'($urandom_range(0, 3)), $urandom_range(0, 7),
                              $urandom_range(0, 255), $urandom_range(0, 15));
            end else begin
                // Charsets change while an enumeration is under way.
                queue_req(OP_RESTART, $urandom_range(0, 7), $urandom_range(0, 255),
                          $urandom_range(0, 15));
                tmp = $urandom_range(1, 4);
                for (k = 0; k < tmp; k++)
                    queue_req(OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 255),
                              $urandom_range(0, 15));
                queue_req($urandom_range(0, 1) ? OP_ADD : OP_CLEAR, $urandom_range(0, 7),
                          $urandom_range(0, 255), $urandom_range(0, 15));
                tmp = $urandom_range(1, 6);
                for (k = 0; k < tmp; k++)
                    queue_req(OP_NEXT, $urandom_range(0, 7), $urandom_range(0, 255),
                              $urandom_range(0, 15));
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (mask_ops_q.size() != 0 || req_active) @(posedge i_clk);
        for (k = 0; k < 5000 && expected_words.size() != 0; k++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("results never delivered", expected_words.size(), 0);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
